>>> hw/rtl/rate_limited_priority_arbiter_top_defines.svh
// Assertion macros for the rate-limited priority arbiter.
`ifndef RATE_LIMITED_PRIORITY_ARBITER_TOP_DEFINES_SVH
`define RATE_LIMITED_PRIORITY_ARBITER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define RLPA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RLPA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rlpa_pkg.sv
// Shared types and constants of the rate-limited priority arbiter.
`default_nettype none

package rlpa_pkg;

    localparam int TIME_W           = 16;
    localparam int SVC_W            = 2;
    localparam int MASK_W           = 4;
    localparam int SVC_CNT_W        = 3;
    localparam int LIMIT_REGS       = 4;
    localparam int MAX_SERVICES_DEF = 4;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 16;

    localparam logic [SVC_CNT_W-1:0] SERVICE_COUNT_RST = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] CFG_SERVICE_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LIMIT_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LIMIT_1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LIMIT_2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATE_LIMIT_3  = 3'd4;

    localparam logic OP_ARBITRATE = 1'b0;
    localparam logic OP_RECORD    = 1'b1;

    typedef struct packed {
        logic              granted;
        logic [SVC_W-1:0]  chosen_service;
        logic [TIME_W-1:0] wait_time;
    } rlpa_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/rlpa_scan.sv
// Priority scan over the services: first eligible grant, shortest remaining wait.
`default_nettype none

module rlpa_scan
    import rlpa_pkg::*;
#(
    parameter int NUM_SERVICES = MAX_SERVICES_DEF
) (
    input  wire logic [TIME_W-1:0]    now,
    input  wire logic [MASK_W-1:0]    pending_mask,
    input  wire logic [SVC_CNT_W-1:0] service_count,
    input  wire logic [TIME_W-1:0]    rate_limit [NUM_SERVICES],
    input  wire logic [TIME_W-1:0]    last_start [NUM_SERVICES],
    output rlpa_result_t              result
);

    logic [SVC_CNT_W-1:0] count_eff;

    assign count_eff = (service_count > SVC_CNT_W'(NUM_SERVICES))
                     ? SVC_CNT_W'(NUM_SERVICES) : service_count;

    always_comb
    begin
        logic              done;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] remain;
        result  = '0;
        done    = 1'b0;
        elapsed = '0;
        remain  = '0;
        for (int i = 0; i < NUM_SERVICES; i++)
        begin
            elapsed = now - last_start[i];
            remain  = rate_limit[i] - elapsed;
            if (!done && (SVC_CNT_W'(i) < count_eff) && pending_mask[i])
            begin
                priority if (rate_limit[i] == '0 || elapsed >= rate_limit[i])
                begin
                    result.granted        = 1'b1;
                    result.chosen_service = SVC_W'(i);
                    done                  = 1'b1;
                end
                else
                begin
                    if (result.wait_time == '0 || remain < result.wait_time)
                    begin
                        result.wait_time      = remain;
                        result.chosen_service = SVC_W'(i);
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rate_limited_priority_arbiter_top.sv
// Top level of the rate-limited fixed-priority arbiter.
// Usage:
//   Input channel (in_valid/in_stall) carries one beat per request: operation 0
//   arbitrates at time now over pending_mask, operation 1 records now as the
//   frame start of service. Output channel (out_valid/out_stall) returns one beat
//   per request: granted, chosen_service and wait_time (all zero for a record).
//   Config port (cfg_we/cfg_index/cfg_data) writes service_count (index 0) and
//   rate_limit_0..3 (index 1..4); write it only while the block is idle.
// Timing:
//   Two register stages: an input register and a result register with the scan
//   between them; the scan output is registered in the result register, and one
//   beat is accepted every cycle while the output side keeps up.
//   A record updates the start-time table as it leaves the input register, so
//   the arbitrate beat right after it already sees the new time.
// Reset: both stages empty, service_count 4, all limits and start times zero.
// Stall: out_stall holds the result register; once the input register is also
//   full, in_stall rises in the same cycle and both stages hold their beats.
`default_nettype none

module rate_limited_priority_arbiter_top
    import rlpa_pkg::*;
#(
    parameter int MAX_SERVICES = MAX_SERVICES_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic                   operation,
    input  wire logic [TIME_W-1:0]      now,
    input  wire logic [MASK_W-1:0]      pending_mask,
    input  wire logic [SVC_W-1:0]       service,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        granted,
    output logic [SVC_W-1:0]            chosen_service,
    output logic [TIME_W-1:0]           wait_time
);

    logic [SVC_CNT_W-1:0] service_count_reg;
    logic [TIME_W-1:0]    rate_limit_reg [LIMIT_REGS];
    logic [TIME_W-1:0]    last_start_reg [MAX_SERVICES];
    logic [TIME_W-1:0]    scan_limit     [MAX_SERVICES];

    logic                 in_valid_reg;
    logic                 op_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [MASK_W-1:0]    pending_reg;
    logic [SVC_W-1:0]     service_reg;

    logic                 out_valid_reg;
    rlpa_result_t         result_reg;
    rlpa_result_t         result_next;
    rlpa_result_t         scan_result;

    logic                 out_ready;
    logic                 in_ready;
    logic                 in_load;
    logic                 out_load;

    assign out_ready = !out_valid_reg || !out_stall;
    assign in_ready  = !in_valid_reg || out_ready;
    assign in_stall  = !in_ready;
    assign in_load   = in_valid && in_ready;
    assign out_load  = in_valid_reg && out_ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            service_count_reg <= SERVICE_COUNT_RST;
            for (int i = 0; i < LIMIT_REGS; i++)
            begin
                rate_limit_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SERVICE_COUNT: service_count_reg <= cfg_data[SVC_CNT_W-1:0];
                CFG_RATE_LIMIT_0:  rate_limit_reg[0] <= cfg_data[TIME_W-1:0];
                CFG_RATE_LIMIT_1:  rate_limit_reg[1] <= cfg_data[TIME_W-1:0];
                CFG_RATE_LIMIT_2:  rate_limit_reg[2] <= cfg_data[TIME_W-1:0];
                CFG_RATE_LIMIT_3:  rate_limit_reg[3] <= cfg_data[TIME_W-1:0];
                default:           ;
            endcase
        end
    end

    // frame start times, written as a record beat leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SERVICES; i++)
            begin
                last_start_reg[i] <= '0;
            end
        end
        else if (out_load && op_reg == OP_RECORD)
        begin
            for (int i = 0; i < MAX_SERVICES; i++)
            begin
                if (service_reg == SVC_W'(i))
                begin
                    last_start_reg[i] <= now_reg;
                end
            end
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            op_reg      <= operation;
            now_reg     <= now;
            pending_reg <= pending_mask;
            service_reg <= service;
        end
    end

    for (genvar g = 0; g < MAX_SERVICES; g++)
    begin : g_limit
        assign scan_limit[g] = rate_limit_reg[g];
    end

    rlpa_scan #(
        .NUM_SERVICES (MAX_SERVICES)
    ) u_scan (
        .now           (now_reg),
        .pending_mask  (pending_reg),
        .service_count (service_count_reg),
        .rate_limit    (scan_limit),
        .last_start    (last_start_reg),
        .result        (scan_result)
    );

    assign result_next = (op_reg == OP_ARBITRATE) ? scan_result : '0;

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted        = result_reg.granted;
    assign chosen_service = result_reg.chosen_service;
    assign wait_time      = result_reg.wait_time;

endmodule

`default_nettype wire

>>> hw/rtl/rlpa_checker.sv
// Port-level assertions for the rate-limited priority arbiter, bound to the top.
`default_nettype none

`include "rate_limited_priority_arbiter_top_defines.svh"

module rlpa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        granted,
    input wire logic [1:0]  chosen_service,
    input wire logic [15:0] wait_time
);

    `RLPA_ASSERT(a_out_hold_valid, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

    `RLPA_ASSERT(a_out_hold_data, out_valid && out_stall |=> $stable(granted) && $stable(chosen_service) && $stable(wait_time), "stalled result beat changed")

    // with nothing in the result register the input side can always move
    `RLPA_ASSERT_ALWAYS(a_no_stall_when_empty, !out_valid |-> !in_stall, "input stalled with empty output")

    // no grant and no wait leaves service 0
    `RLPA_ASSERT(a_idle_choice, out_valid && !granted && wait_time == 16'd0 |-> chosen_service == 2'd0, "chosen service set without grant or wait")

endmodule

bind rate_limited_priority_arbiter_top rlpa_checker u_rlpa_checker (.*);

`default_nettype wire
